// File: rtl/kdpc_pkg.sv
// Package with the shared types, constants and codes of the key debounce classifier.
`timescale 1ns / 1ps

package kdpc_pkg;

  // Number of keys handled, and the width of one key's event code.
  localparam int NUM_KEYS = 3;
  localparam int EVENT_W  = 8;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef logic [7:0]         tick_count_t;
  typedef logic [EVENT_W-1:0] key_event_t;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_HOLD_LIMIT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_HOLD_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_HOLD_LIMIT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HOLD_TICKS    = 3'd4;

  // Register values after reset.
  localparam tick_count_t RST_DEBOUNCE_TICKS    = 8'd15;
  localparam tick_count_t RST_SHORT_HOLD_LIMIT  = 8'd46;
  localparam tick_count_t RST_MEDIUM_HOLD_LIMIT = 8'd78;
  localparam tick_count_t RST_LONG_HOLD_LIMIT   = 8'd156;
  localparam tick_count_t RST_MAX_HOLD_TICKS    = 8'd187;

  // Counters saturate at this value.
  localparam tick_count_t COUNT_MAX = 8'hFF;

  // Event codes: held thresholds, and the release mark with its class.
  localparam key_event_t EVT_NONE        = 8'h00;
  localparam key_event_t EVT_HELD_SHORT  = 8'h01;
  localparam key_event_t EVT_HELD_MEDIUM = 8'h02;
  localparam key_event_t EVT_HELD_LONG   = 8'h03;
  localparam key_event_t EVT_RELEASED    = 8'h80;
  localparam key_event_t CLASS_SHORT     = 8'h01;
  localparam key_event_t CLASS_MEDIUM    = 8'h02;
  localparam key_event_t CLASS_LONG      = 8'h03;
  localparam key_event_t CLASS_BEYOND    = 8'h04;

  // Configuration register set, shared by all keys.
  typedef struct packed {
    tick_count_t debounce_ticks;
    tick_count_t short_hold_limit;
    tick_count_t medium_hold_limit;
    tick_count_t long_hold_limit;
    tick_count_t max_hold_ticks;
  } kdpc_cfg_t;

  // Per-item control sent to every key cell.
  typedef struct packed {
    logic step;
    logic clear;
    logic tick_fast;
    logic tick_slow;
  } kdpc_ctl_t;

  // State of one key as it stands after the current item.
  typedef struct packed {
    logic       pressed;
    logic       changed;
    key_event_t key_event;
  } kdpc_key_view_t;

endpackage

// File: rtl/kdpc_in_if.sv
// Input channel interface: raw pin levels and request bits with valid/ready.
`timescale 1ns / 1ps

interface kdpc_in_if;
  import kdpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] pin_levels;
  logic                tick_fast;
  logic                tick_slow;
  logic                clear_flags;

  modport source (
    output valid, pin_levels, tick_fast, tick_slow, clear_flags,
    input  ready
  );

  modport sink (
    input  valid, pin_levels, tick_fast, tick_slow, clear_flags,
    output ready
  );

endinterface

// File: rtl/kdpc_out_if.sv
// Output channel interface: debounced states, change flags and events with valid/ready.
`timescale 1ns / 1ps

interface kdpc_out_if;
  import kdpc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [NUM_KEYS-1:0]         stable_pressed;
  logic [NUM_KEYS-1:0]         change_flags;
  logic [EVENT_W*NUM_KEYS-1:0] key_events;

  modport source (
    output valid, stable_pressed, change_flags, key_events,
    input  ready
  );

  modport sink (
    input  valid, stable_pressed, change_flags, key_events,
    output ready
  );

endinterface

// File: rtl/kdpc_key.sv
// Per-key cell: debounce counter, hold timer, change flag and event register.
`timescale 1ns / 1ps

module kdpc_key (
  input  logic                     clk,
  input  logic                     rst,
  input  kdpc_pkg::kdpc_ctl_t      ctl,
  input  logic                     pressed_raw,
  input  kdpc_pkg::kdpc_cfg_t      cfg,
  output kdpc_pkg::kdpc_key_view_t view_next
);
  import kdpc_pkg::*;

  logic        stable;
  logic        changed;
  key_event_t  key_event;
  tick_count_t bounce_count;
  tick_count_t hold_time;

  logic        stable_next;
  logic        changed_next;
  key_event_t  key_event_next;
  tick_count_t bounce_count_next;
  tick_count_t hold_time_next;

  logic        changed_clr;
  key_event_t  event_clr;
  tick_count_t count_run;
  tick_count_t hold_inc;
  key_event_t  held_event;
  key_event_t  release_class;

  // Clear, then the fast-tick debounce, then the slow-tick hold timing.
  always_comb begin
    changed_clr = ctl.clear ? 1'b0 : changed;
    event_clr   = ctl.clear ? EVT_NONE : key_event;

    // The debounce counter runs while the raw level differs from the stable one.
    if (pressed_raw != stable) begin
      count_run = (bounce_count != COUNT_MAX) ? bounce_count + 8'd1 : bounce_count;
    end else begin
      count_run = '0;
    end

    stable_next       = stable;
    changed_next      = changed_clr;
    bounce_count_next = bounce_count;
    if (ctl.tick_fast) begin
      if (count_run >= cfg.debounce_ticks) begin
        stable_next       = pressed_raw;
        changed_next      = 1'b1;
        bounce_count_next = '0;
      end else begin
        bounce_count_next = count_run;
      end
    end

    // Hold time saturates one above the maximum, and never wraps.
    if (hold_time <= cfg.max_hold_ticks && hold_time != COUNT_MAX) begin
      hold_inc = hold_time + 8'd1;
    end else begin
      hold_inc = hold_time;
    end

    // An exact threshold match while held; the first one wins.
    priority if (hold_inc == cfg.short_hold_limit) begin
      held_event = EVT_HELD_SHORT;
    end else if (hold_inc == cfg.medium_hold_limit) begin
      held_event = EVT_HELD_MEDIUM;
    end else if (hold_inc == cfg.long_hold_limit) begin
      held_event = EVT_HELD_LONG;
    end else begin
      held_event = event_clr;
    end

    // Release class: the first threshold that the hold time does not exceed.
    priority if (hold_time <= cfg.short_hold_limit) begin
      release_class = CLASS_SHORT;
    end else if (hold_time <= cfg.medium_hold_limit) begin
      release_class = CLASS_MEDIUM;
    end else if (hold_time <= cfg.long_hold_limit) begin
      release_class = CLASS_LONG;
    end else begin
      release_class = CLASS_BEYOND;
    end

    key_event_next = event_clr;
    hold_time_next = hold_time;
    if (ctl.tick_slow) begin
      if (stable_next) begin
        hold_time_next = hold_inc;
        key_event_next = held_event;
      end else begin
        hold_time_next = '0;
        if (hold_time != '0) begin
          key_event_next = EVT_RELEASED | release_class;
        end
      end
    end
  end

  assign view_next = '{pressed: stable_next, changed: changed_next, key_event: key_event_next};

  // Key state advances once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable       <= 1'b0;
      changed      <= 1'b0;
      key_event    <= EVT_NONE;
      bounce_count <= '0;
      hold_time    <= '0;
    end else if (ctl.step) begin
      stable       <= stable_next;
      changed      <= changed_next;
      key_event    <= key_event_next;
      bounce_count <= bounce_count_next;
      hold_time    <= hold_time_next;
    end
  end

`ifndef SYNTHESIS
  // A fast tick with the raw level equal to the stable state leaves the counter at zero.
  assert property (@(posedge clk) disable iff (rst)
    ctl.step && ctl.tick_fast && (pressed_raw == stable) |=> bounce_count == '0)
    else $error("debounce counter not restarted on matching level");

  // A slow tick on a released key always clears the hold time.
  assert property (@(posedge clk) disable iff (rst)
    ctl.step && ctl.tick_slow && !stable_next |=> hold_time == '0)
    else $error("hold time not cleared on release");

  // A clear with no tick leaves neither a change flag nor an event.
  assert property (@(posedge clk) disable iff (rst)
    ctl.step && ctl.clear && !ctl.tick_fast && !ctl.tick_slow
    |=> !changed && key_event == EVT_NONE)
    else $error("clear request did not clear flag and event");

  // Without an item the key state holds.
  assert property (@(posedge clk) disable iff (rst)
    !ctl.step |=> $stable(stable) && $stable(hold_time) && $stable(bounce_count)
                  && $stable(key_event) && $stable(changed))
    else $error("key state moved without an item");
`endif

endmodule

// File: rtl/key_debounce_press_classifier_core.sv
// Top level of the key debounce and press-length classifier.
`timescale 1ns / 1ps

// Channel   Direction  Handshake     Payload
// in_ch     in         valid/ready   pin_levels, tick_fast, tick_slow, clear_flags
// out_ch    out        valid/ready   stable_pressed, change_flags, key_events
// cfg       in         cfg_we        cfg_index, cfg_wdata (no read-back)
//
// One item is taken every cycle while out_ch does not stall. The key cells compute from
// the input register straight into the output register, so an item passes the input register
// and then the output register before its result is offered. Reset is synchronous and
// restores the register defaults and all key state. When out_ch stalls the result
// holds, the input register fills, and in_ch ready falls only once both are occupied.

module key_debounce_press_classifier_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  kdpc_in_if.sink                             in_ch,
  kdpc_out_if.source                          out_ch
);
  import kdpc_pkg::*;

  kdpc_cfg_t           cfg;

  logic                in_valid_q;
  logic [NUM_KEYS-1:0] pin_q;
  logic                fast_q;
  logic                slow_q;
  logic                clear_q;

  logic                out_valid;
  logic [NUM_KEYS-1:0]         out_pressed;
  logic [NUM_KEYS-1:0]         out_flags;
  logic [EVENT_W*NUM_KEYS-1:0] out_events;

  logic                advance;
  kdpc_ctl_t           ctl;
  kdpc_key_view_t      key_view [NUM_KEYS];

  logic [NUM_KEYS-1:0]         pressed_next;
  logic [NUM_KEYS-1:0]         flags_next;
  logic [EVENT_W*NUM_KEYS-1:0] events_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= RST_DEBOUNCE_TICKS;
      cfg.short_hold_limit  <= RST_SHORT_HOLD_LIMIT;
      cfg.medium_hold_limit <= RST_MEDIUM_HOLD_LIMIT;
      cfg.long_hold_limit   <= RST_LONG_HOLD_LIMIT;
      cfg.max_hold_ticks    <= RST_MAX_HOLD_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS:    cfg.debounce_ticks    <= cfg_wdata;
        CFG_SHORT_HOLD_LIMIT:  cfg.short_hold_limit  <= cfg_wdata;
        CFG_MEDIUM_HOLD_LIMIT: cfg.medium_hold_limit <= cfg_wdata;
        CFG_LONG_HOLD_LIMIT:   cfg.long_hold_limit   <= cfg_wdata;
        CFG_MAX_HOLD_TICKS:    cfg.max_hold_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the held item moves on when the output register is free or being taken.
  assign advance      = !out_valid || out_ch.ready;
  assign in_ch.ready  = !in_valid_q || advance;
  assign ctl.step      = in_valid_q && advance;
  assign ctl.clear     = clear_q;
  assign ctl.tick_fast = fast_q;
  assign ctl.tick_slow = slow_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= in_valid_q;
      end
    end
  end

  // Input register captures each transfer.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pin_q   <= in_ch.pin_levels;
      fast_q  <= in_ch.tick_fast;
      slow_q  <= in_ch.tick_slow;
      clear_q <= in_ch.clear_flags;
    end
  end

  // One cell per key; pins are active low.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdpc_key u_key (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .pressed_raw (!pin_q[k]),
      .cfg         (cfg),
      .view_next   (key_view[k])
    );
  end

  // Gather the per-key views into the result fields.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      pressed_next[k]                = key_view[k].pressed;
      flags_next[k]                  = key_view[k].changed;
      events_next[EVENT_W*k +: EVENT_W] = key_view[k].key_event;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_pressed <= pressed_next;
      out_flags   <= flags_next;
      out_events  <= events_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.stable_pressed = out_pressed;
  assign out_ch.change_flags   = out_flags;
  assign out_ch.key_events     = out_events;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the key debounce and press-length classifier core.
`timescale 1ns / 1ps

module testbench;
  import kdpc_pkg::*;

  // Run limits and pacing.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int REPORT_LIMIT    = 10;

  // Register indexes that select no register; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // What one output transfer carries.
  typedef struct packed {
    logic [NUM_KEYS-1:0]         pressed;
    logic [NUM_KEYS-1:0]         changed;
    logic [EVENT_W*NUM_KEYS-1:0] events;
  } panel_view_t;

  // One row of the directed table: either a register write or an input item.
  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    tick_count_t            reg_value;
    logic [NUM_KEYS-1:0]    pins;
    logic                   fast;
    logic                   slow;
    logic                   clear;
    bit                     typed;
    panel_view_t            want;
  } stim_row_t;

  // Settings and stimulus shape of one random phase.
  typedef struct {
    tick_count_t         deb;
    tick_count_t         short_lim;
    tick_count_t         mid_lim;
    tick_count_t         long_lim;
    tick_count_t         max_hold;
    int                  items;
    int                  pct_fast;
    int                  pct_slow;
    int                  run_lo;
    int                  run_hi;
    logic [NUM_KEYS-1:0] start_pins;
    bit                  idle;
    bit                  noise;
    bit                  squeeze;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  kdpc_in_if  in_ch ();
  kdpc_out_if out_ch ();

  key_debounce_press_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the registers and of every key's state.
  kdpc_cfg_t   reg_shadow;
  logic        key_down   [NUM_KEYS];
  tick_count_t bounce_cnt [NUM_KEYS];
  tick_count_t hold_ticks [NUM_KEYS];
  logic        key_changed[NUM_KEYS];
  key_event_t  key_evt    [NUM_KEYS];

  panel_view_t expected_views[$];
  stim_row_t   directed_rows[$];
  phase_t      phases[$];

  int fail_count   = 0;
  int cycle_count  = 0;
  bit idling_on    = 1'b1;
  bit hold_off_req = 1'b0;

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overall time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic panel_view_t make_view(logic [NUM_KEYS-1:0] pressed,
                                            logic [NUM_KEYS-1:0] changed,
                                            logic [EVENT_W*NUM_KEYS-1:0] events);
    panel_view_t v;
    v.pressed = pressed;
    v.changed = changed;
    v.events  = events;
    return v;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, tick_count_t val);
    stim_row_t r;
    r = '{kind: ROW_REG, default: '0};
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [NUM_KEYS-1:0] pins, logic fast,
                                         logic slow, logic clear);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.pins  = pins;
    r.fast  = fast;
    r.slow  = slow;
    r.clear = clear;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [NUM_KEYS-1:0] pins, logic fast,
                                          logic slow, logic clear, panel_view_t want);
    stim_row_t r;
    r = item_row(pins, fast, slow, clear);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // Predictor: applies one item to the shadow state and returns the view after it.
  task automatic classify_item(input logic [NUM_KEYS-1:0] pins, input logic fast,
                               input logic slow, input logic clear,
                               output panel_view_t view);
    logic pressed_now;
    if (clear) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_changed[k] = 1'b0;
        key_evt[k]     = EVT_NONE;
      end
    end
    // Debounce on the fast tick; the level must differ for the limit in ticks.
    if (fast) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pressed_now = ~pins[k];
        if (pressed_now != key_down[k]) begin
          if (bounce_cnt[k] != COUNT_MAX) bounce_cnt[k] = bounce_cnt[k] + 8'd1;
        end else begin
          bounce_cnt[k] = '0;
        end
        if (bounce_cnt[k] >= reg_shadow.debounce_ticks) begin
          key_down[k]    = pressed_now;
          key_changed[k] = 1'b1;
          bounce_cnt[k]  = '0;
        end
      end
    end
    // Hold timing on the slow tick: thresholds while held, a class on release.
    if (slow) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (key_down[k]) begin
          if (hold_ticks[k] <= reg_shadow.max_hold_ticks && hold_ticks[k] != COUNT_MAX)
            hold_ticks[k] = hold_ticks[k] + 8'd1;
          if (hold_ticks[k] == reg_shadow.short_hold_limit)       key_evt[k] = EVT_HELD_SHORT;
          else if (hold_ticks[k] == reg_shadow.medium_hold_limit) key_evt[k] = EVT_HELD_MEDIUM;
          else if (hold_ticks[k] == reg_shadow.long_hold_limit)   key_evt[k] = EVT_HELD_LONG;
        end else begin
          if (hold_ticks[k] != '0) begin
            if (hold_ticks[k] <= reg_shadow.short_hold_limit)
              key_evt[k] = EVT_RELEASED | CLASS_SHORT;
            else if (hold_ticks[k] <= reg_shadow.medium_hold_limit)
              key_evt[k] = EVT_RELEASED | CLASS_MEDIUM;
            else if (hold_ticks[k] <= reg_shadow.long_hold_limit)
              key_evt[k] = EVT_RELEASED | CLASS_LONG;
            else
              key_evt[k] = EVT_RELEASED | CLASS_BEYOND;
          end
          hold_ticks[k] = '0;
        end
      end
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      view.pressed[k]                 = key_down[k];
      view.changed[k]                 = key_changed[k];
      view.events[k*EVENT_W +: EVENT_W] = key_evt[k];
    end
  endtask

  // Register write, made only once every expected result has been taken.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input tick_count_t val);
    in_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_TICKS:    reg_shadow.debounce_ticks    = val;
      CFG_SHORT_HOLD_LIMIT:  reg_shadow.short_hold_limit  = val;
      CFG_MEDIUM_HOLD_LIMIT: reg_shadow.medium_hold_limit = val;
      CFG_LONG_HOLD_LIMIT:   reg_shadow.long_hold_limit   = val;
      CFG_MAX_HOLD_TICKS:    reg_shadow.max_hold_ticks    = val;
      default: ;
    endcase
  endtask

  // Offer one item after a random gap; on its transfer, record what must come out.
  task automatic send_item(input logic [NUM_KEYS-1:0] pins, input logic fast,
                           input logic slow, input logic clear,
                           input bit typed, input panel_view_t want);
    int gap;
    panel_view_t predicted;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 35) gap = idle_length();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pin_levels  <= pins;
    in_ch.tick_fast   <= fast;
    in_ch.tick_slow   <= slow;
    in_ch.clear_flags <= clear;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    classify_item(pins, fast, slow, clear, predicted);
    expected_views.push_back(typed ? want : predicted);
  endtask

  // Compare one output transfer with the oldest expectation.
  task automatic check_view(input panel_view_t got);
    panel_view_t want;
    if (expected_views.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("unexpected result: pressed=%b changed=%b events=%h",
                 got.pressed, got.changed, got.events);
    end else begin
      want = expected_views.pop_front();
      if (got.pressed !== want.pressed || got.changed !== want.changed ||
          got.events !== want.events) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("mismatch: expected pressed=%b changed=%b events=%h,",
                   want.pressed, want.changed, want.events,
                   " got pressed=%b changed=%b events=%h",
                   got.pressed, got.changed, got.events);
      end
    end
  endtask

  // Result side: takes transfers and stalls at random or on a hold-off request.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_view({out_ch.stable_pressed, out_ch.change_flags, out_ch.key_events});
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 99) < 25) begin
        stall_left = idle_length() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin : stimulus
    phase_t ph;
    stim_row_t row;
    logic [NUM_KEYS-1:0] target;
    logic [NUM_KEYS-1:0] pins;
    int run_left;
    panel_view_t none_view;

    none_view = '0;
    in_ch.valid       <= 1'b0;
    in_ch.pin_levels  <= '1;
    in_ch.tick_fast   <= 1'b0;
    in_ch.tick_slow   <= 1'b0;
    in_ch.clear_flags <= 1'b0;

    reg_shadow.debounce_ticks    = RST_DEBOUNCE_TICKS;
    reg_shadow.short_hold_limit  = RST_SHORT_HOLD_LIMIT;
    reg_shadow.medium_hold_limit = RST_MEDIUM_HOLD_LIMIT;
    reg_shadow.long_hold_limit   = RST_LONG_HOLD_LIMIT;
    reg_shadow.max_hold_ticks    = RST_MAX_HOLD_TICKS;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_down[k]    = 1'b0;
      bounce_cnt[k]  = '0;
      hold_ticks[k]  = '0;
      key_changed[k] = 1'b0;
      key_evt[k]     = EVT_NONE;
    end

    // Directed table.  Nothing pressed and nothing flagged straight after reset.
    directed_rows.push_back(typed_row(3'b111, 1'b0, 1'b0, 1'b0, none_view));
    // Short limits so that every threshold and saturation come within a few ticks.
    directed_rows.push_back(reg_row(CFG_DEBOUNCE_TICKS, 8'd1));
    directed_rows.push_back(reg_row(CFG_SHORT_HOLD_LIMIT, 8'd2));
    directed_rows.push_back(reg_row(CFG_MEDIUM_HOLD_LIMIT, 8'd3));
    directed_rows.push_back(reg_row(CFG_LONG_HOLD_LIMIT, 8'd6));
    directed_rows.push_back(reg_row(CFG_MAX_HOLD_TICKS, 8'd5));
    directed_rows.push_back(typed_row(3'b000, 1'b1, 1'b0, 1'b0, make_view(3'b111, 3'b111, '0)));
    repeat (6) directed_rows.push_back(item_row(3'b000, 1'b0, 1'b1, 1'b0));
    directed_rows.push_back(typed_row(3'b000, 1'b0, 1'b0, 1'b1, make_view(3'b111, 3'b000, '0)));
    // A saturated hold still sets its threshold event again.
    directed_rows.push_back(item_row(3'b000, 1'b0, 1'b1, 1'b0));
    // Both ticks together: release is seen by the slow work in the same item.
    directed_rows.push_back(item_row(3'b111, 1'b1, 1'b1, 1'b0));
    // Writes to unused indexes change nothing.
    directed_rows.push_back(reg_row(REG_SPARE_LO, 8'd0));
    directed_rows.push_back(reg_row(REG_SPARE_HI, 8'hFF));
    // Zero debounce limit, zero threshold and a hold that saturates at the top.
    directed_rows.push_back(reg_row(CFG_DEBOUNCE_TICKS, 8'd0));
    directed_rows.push_back(reg_row(CFG_SHORT_HOLD_LIMIT, 8'd0));
    directed_rows.push_back(reg_row(CFG_MAX_HOLD_TICKS, 8'hFF));
    directed_rows.push_back(item_row(3'b101, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(item_row(3'b101, 1'b1, 1'b0, 1'b1));
    repeat (3) directed_rows.push_back(item_row(3'b101, 1'b0, 1'b1, 1'b0));
    // Top limits, then the debounce limit lowered below a running count.
    directed_rows.push_back(reg_row(CFG_DEBOUNCE_TICKS, 8'hFF));
    directed_rows.push_back(reg_row(CFG_MEDIUM_HOLD_LIMIT, 8'd254));
    directed_rows.push_back(reg_row(CFG_LONG_HOLD_LIMIT, 8'hFF));
    repeat (3) directed_rows.push_back(item_row(3'b010, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(reg_row(CFG_DEBOUNCE_TICKS, 8'd2));
    directed_rows.push_back(item_row(3'b010, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(item_row(3'b000, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(item_row(3'b111, 1'b1, 1'b1, 1'b1));

    // Random phases.  The first one also carries the long hold-off on the result side.
    phases.push_back('{deb: 8'd1, short_lim: 8'd2, mid_lim: 8'd5, long_lim: 8'd9,
                       max_hold: 8'd12, items: 110, pct_fast: 70, pct_slow: 60,
                       run_lo: 1, run_hi: 25, start_pins: 3'b110, idle: 1'b1,
                       noise: 1'b1, squeeze: 1'b1});
    phases.push_back('{deb: 8'($urandom_range(1, 4)), short_lim: 8'($urandom_range(0, 15)),
                       mid_lim: 8'($urandom_range(0, 15)), long_lim: 8'($urandom_range(0, 15)),
                       max_hold: 8'($urandom_range(0, 20)), items: 110, pct_fast: 60,
                       pct_slow: 50, run_lo: 1, run_hi: 30,
                       start_pins: 3'($urandom_range(0, 7)), idle: 1'b0, noise: 1'b1,
                       squeeze: 1'b0});
    phases.push_back('{deb: 8'd3, short_lim: 8'd0, mid_lim: 8'hFF, long_lim: 8'd128,
                       max_hold: 8'd254, items: 90, pct_fast: 80, pct_slow: 80,
                       run_lo: 5, run_hi: 60, start_pins: 3'b010, idle: 1'b1,
                       noise: 1'b1, squeeze: 1'b0});
    // One press held long enough for the hold time to saturate at the top.
    phases.push_back('{deb: 8'd1, short_lim: 8'd250, mid_lim: 8'd254, long_lim: 8'hFF,
                       max_hold: 8'hFF, items: 280, pct_fast: 100, pct_slow: 100,
                       run_lo: 270, run_hi: 270, start_pins: 3'b000, idle: 1'b1,
                       noise: 1'b0, squeeze: 1'b0});
    phases.push_back('{deb: 8'($urandom_range(0, 6)), short_lim: 8'($urandom_range(0, 255)),
                       mid_lim: 8'($urandom_range(0, 255)), long_lim: 8'($urandom_range(0, 255)),
                       max_hold: 8'($urandom_range(0, 255)), items: 100, pct_fast: 50,
                       pct_slow: 50, run_lo: 1, run_hi: 40,
                       start_pins: 3'($urandom_range(0, 7)), idle: 1'b1, noise: 1'b1,
                       squeeze: 1'b0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_index, row.reg_value);
      end else begin
        send_item(row.pins, row.fast, row.slow, row.clear, row.typed, row.want);
      end
    end

    // Random part: pin patterns held for runs, with occasional bounce on one key.
    foreach (phases[p]) begin
      ph = phases[p];
      write_reg(CFG_DEBOUNCE_TICKS, ph.deb);
      write_reg(CFG_SHORT_HOLD_LIMIT, ph.short_lim);
      write_reg(CFG_MEDIUM_HOLD_LIMIT, ph.mid_lim);
      write_reg(CFG_LONG_HOLD_LIMIT, ph.long_lim);
      write_reg(CFG_MAX_HOLD_TICKS, ph.max_hold);
      idling_on = ph.idle;
      if (ph.squeeze) hold_off_req = 1'b1;
      target   = ph.start_pins;
      run_left = $urandom_range(ph.run_lo, ph.run_hi);
      for (int i = 0; i < ph.items; i++) begin
        if (run_left == 0) begin
          target   = 3'($urandom_range(0, 7));
          run_left = $urandom_range(ph.run_lo, ph.run_hi);
        end
        run_left--;
        pins = target;
        if (ph.noise && $urandom_range(0, 9) == 0)
          pins[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
        send_item(pins, $urandom_range(0, 99) < ph.pct_fast,
                  $urandom_range(0, 99) < ph.pct_slow,
                  $urandom_range(0, 39) == 0, 1'b0, none_view);
      end
    end

    // Let every outstanding result arrive, then a little longer.
    in_ch.valid <= 1'b0;
    idling_on = 1'b1;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
